>>> hdl/obqt_pkg.sv
// Shared types and character codes for the bracket and quote tracker.
package obqt_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DEPTH_OUT_W     = 7;

  typedef enum logic [2:0] {
    K_ROUND   = 3'd0,
    K_SQUARE  = 3'd1,
    K_CURLY   = 3'd2,
    K_COMMENT = 3'd3,
    K_SQUOTE  = 3'd4,
    K_DQUOTE  = 3'd5,
    K_NONE    = 3'd7
  } kind_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    kind_t kind;
  } stack_op_t;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LROUND  = 8'h28;
  localparam logic [7:0] CH_RROUND  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;

endpackage

>>> hdl/obqt_cell.sv
// One stack cell: holds one closer kind, shifts with its neighbors on push or pop.
module obqt_cell (
  input  logic               clk,
  input  obqt_pkg::stack_op_t op,
  input  obqt_pkg::kind_t    from_above,
  input  obqt_pkg::kind_t    from_below,
  output obqt_pkg::kind_t    kind
);
  import obqt_pkg::*;

  kind_t kind_r;

  always_ff @(posedge clk) begin
    if (op.push) begin
      kind_r <= from_above;
    end else if (op.pop) begin
      kind_r <= from_below;
    end
  end

  assign kind = kind_r;

endmodule

>>> hdl/obqt_ctrl.sv
// Byte scanner: mode flags, stack count and push/pop decisions.
module obqt_ctrl #(
  parameter int STACK_DEPTH = obqt_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               acc,
  input  logic [7:0]                         text_byte,
  input  logic                               line_end,
  input  obqt_pkg::kind_t                    top_cell_kind,
  output obqt_pkg::stack_op_t                op,
  output logic [obqt_pkg::DEPTH_OUT_W-1:0]   depth,
  output logic                               complete,
  output logic                               overflow
);
  import obqt_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int EXT_W = (CNT_W > DEPTH_OUT_W) ? CNT_W : DEPTH_OUT_W;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             esc_r, esc_nxt;
  logic             slash_r, slash_nxt;
  logic             star_r, star_nxt;
  logic             rol_r, rol_nxt;
  logic             req, push, pop, full;
  kind_t            top, kind;
  logic [EXT_W-1:0] cnt_ext;

  assign full = (cnt_r == CNT_W'(STACK_DEPTH));
  assign top  = (cnt_r == '0) ? K_NONE : top_cell_kind;

  always_comb begin
    esc_nxt   = esc_r;
    slash_nxt = slash_r;
    star_nxt  = star_r;
    rol_nxt   = rol_r;
    req       = 1'b0;
    pop       = 1'b0;
    push      = 1'b0;
    kind      = K_ROUND;
    complete  = 1'b0;
    overflow  = 1'b0;
    if (line_end) begin
      esc_nxt   = 1'b0;
      slash_nxt = 1'b0;
      star_nxt  = 1'b0;
      rol_nxt   = 1'b0;
      complete  = (cnt_r == '0);
    end else if (!rol_r) begin
      if (top == K_SQUOTE || top == K_DQUOTE) begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (text_byte == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (text_byte == ((top == K_SQUOTE) ? CH_SQUOTE : CH_DQUOTE)) begin
          pop = 1'b1;
        end
      end else if (top == K_COMMENT) begin
        if (star_r && text_byte == CH_SLASH) begin
          star_nxt = 1'b0;
          pop      = 1'b1;
        end else begin
          star_nxt = (text_byte == CH_STAR);
        end
      end else if (slash_r && text_byte == CH_STAR) begin
        slash_nxt = 1'b0;
        star_nxt  = 1'b0;
        req       = 1'b1;
        kind      = K_COMMENT;
      end else begin
        slash_nxt = 1'b0;
        case (text_byte)
          CH_HASH:    rol_nxt = 1'b1;
          CH_SLASH:   slash_nxt = 1'b1;
          CH_LROUND: begin
            req  = 1'b1;
            kind = K_ROUND;
          end
          CH_LSQUARE: begin
            req  = 1'b1;
            kind = K_SQUARE;
          end
          CH_LCURLY: begin
            req  = 1'b1;
            kind = K_CURLY;
          end
          CH_SQUOTE: begin
            esc_nxt = 1'b0;
            req     = 1'b1;
            kind    = K_SQUOTE;
          end
          CH_DQUOTE: begin
            esc_nxt = 1'b0;
            req     = 1'b1;
            kind    = K_DQUOTE;
          end
          CH_RROUND:  pop = (top == K_ROUND);
          CH_RSQUARE: pop = (top == K_SQUARE);
          CH_RCURLY:  pop = (top == K_CURLY);
          default:    ;
        endcase
      end
    end
    if (req) begin
      if (full) begin
        overflow = 1'b1;
      end else begin
        push = 1'b1;
      end
    end
    if (push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      esc_r   <= 1'b0;
      slash_r <= 1'b0;
      star_r  <= 1'b0;
      rol_r   <= 1'b0;
    end else if (acc) begin
      cnt_r   <= cnt_nxt;
      esc_r   <= esc_nxt;
      slash_r <= slash_nxt;
      star_r  <= star_nxt;
      rol_r   <= rol_nxt;
    end
  end

  assign op.push = acc & push;
  assign op.pop  = acc & pop;
  assign op.kind = kind;

  assign cnt_ext = EXT_W'(cnt_nxt);
  assign depth   = cnt_ext[DEPTH_OUT_W-1:0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_ovf_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && overflow |=> cnt_r == $past(cnt_r))
    else $error("dropped push changed the count");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow |-> full && !push)
    else $error("overflow flagged with room left");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({op.push, op.pop}))
    else $error("push and pop in one cycle");

endmodule

>>> hdl/open_bracket_quote_tracker_unit.sv
// Top level of the bracket, quote and comment balance tracker.
// Takes one item per clock (a source byte or a line-end mark) and returns one
// result item per input item, in the cycle after acceptance, from an output
// register; with the result side not stalling, an item can be accepted in
// every cycle. The stack of expected closers is a chain of STACK_DEPTH cells
// that shift as one on a push or pop, so every stack operation is one shift of
// the whole chain; the decode of the byte against the top cell and the mode
// flags sets the cycle time. Reset leaves the stack empty with no clearing pass.
module open_bracket_quote_tracker_unit #(
  parameter int STACK_DEPTH = obqt_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_text_byte,
  input  logic                             in_line_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [obqt_pkg::DEPTH_OUT_W-1:0] out_open_depth,
  output logic                             out_expression_complete,
  output logic                             out_stack_overflow
);
  import obqt_pkg::*;

  logic                   in_acc;
  stack_op_t              op;
  kind_t                  chain [STACK_DEPTH];
  logic [DEPTH_OUT_W-1:0] depth;
  logic                   complete, overflow;

  logic                   out_valid_r;
  logic [DEPTH_OUT_W-1:0] depth_r;
  logic                   complete_r, overflow_r;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  obqt_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .text_byte     (in_text_byte),
    .line_end      (in_line_end),
    .top_cell_kind (chain[0]),
    .op            (op),
    .depth         (depth),
    .complete      (complete),
    .overflow      (overflow)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t above, below;
    if (i == 0) begin : g_first
      assign above = op.kind;
    end else begin : g_mid_a
      assign above = chain[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = chain[i];
    end else begin : g_mid_b
      assign below = chain[i+1];
    end
    obqt_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .kind       (chain[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      depth_r    <= depth;
      complete_r <= complete;
      overflow_r <= overflow;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_open_depth          = depth_r;
  assign out_expression_complete = complete_r;
  assign out_stack_overflow      = overflow_r;

  a_cmpl_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && complete_r |-> depth_r == '0)
    else $error("complete reported with open constructs");

  a_cmpl_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(complete_r && overflow_r))
    else $error("complete and overflow in one item");

  a_shift_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (op.push || op.pop) |-> in_acc)
    else $error("stack shifted without an accepted item");

endmodule

>>> tb/sv/tb.sv
// Testbench for the bracket, quote and comment balance tracker: predicts and checks results.
`timescale 1ns / 1ps

module tb;
  import obqt_pkg::*;

  class closer_scoreboard;
    typedef struct packed {
      logic [DEPTH_OUT_W-1:0] depth;
      logic                   complete;
      logic                   overflow;
    } line_report_t;

    kind_t        closers [STACK_DEPTH_DEF];
    int unsigned  depth_now;
    bit           escape_on;
    bit           slash_on;
    bit           star_on;
    bit           line_skipped;
    line_report_t due [$];
    int unsigned  mismatches;

    function kind_t top_kind();
      if (depth_now == 0) return K_NONE;
      return closers[depth_now - 1];
    endfunction

    // returns 1 when the push is dropped
    function bit push_kind(kind_t k);
      if (depth_now >= STACK_DEPTH_DEF) return 1'b1;
      closers[depth_now] = k;
      depth_now++;
      return 1'b0;
    endfunction

    function void pop_kind();
      if (depth_now > 0) depth_now--;
    endfunction

    function bit code_byte(logic [7:0] b);
      if (slash_on && b == CH_STAR) begin
        slash_on = 1'b0;
        star_on  = 1'b0;
        return push_kind(K_COMMENT);
      end
      slash_on = 1'b0;
      case (b)
        CH_HASH: line_skipped = 1'b1;
        CH_SLASH: slash_on = 1'b1;
        CH_LROUND: return push_kind(K_ROUND);
        CH_LSQUARE: return push_kind(K_SQUARE);
        CH_LCURLY: return push_kind(K_CURLY);
        CH_SQUOTE: begin
          escape_on = 1'b0;
          return push_kind(K_SQUOTE);
        end
        CH_DQUOTE: begin
          escape_on = 1'b0;
          return push_kind(K_DQUOTE);
        end
        CH_RROUND: if (top_kind() == K_ROUND) pop_kind();
        CH_RSQUARE: if (top_kind() == K_SQUARE) pop_kind();
        CH_RCURLY: if (top_kind() == K_CURLY) pop_kind();
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_item(logic [7:0] b, logic le);
      kind_t        t;
      line_report_t r;
      r = '0;
      if (le) begin
        escape_on    = 1'b0;
        slash_on     = 1'b0;
        star_on      = 1'b0;
        line_skipped = 1'b0;
        r.complete   = (depth_now == 0);
      end else if (!line_skipped) begin
        t = top_kind();
        if (t == K_SQUOTE || t == K_DQUOTE) begin
          if (escape_on) escape_on = 1'b0;
          else if (b == CH_BSLASH) escape_on = 1'b1;
          else if (b == ((t == K_SQUOTE) ? CH_SQUOTE : CH_DQUOTE)) pop_kind();
        end else if (t == K_COMMENT) begin
          if (star_on && b == CH_SLASH) begin
            star_on = 1'b0;
            pop_kind();
          end else begin
            star_on = (b == CH_STAR);
          end
        end else begin
          r.overflow = code_byte(b);
        end
      end
      r.depth = depth_now[DEPTH_OUT_W-1:0];
      due.push_back(r);
    endfunction

    function void check_result(logic [DEPTH_OUT_W-1:0] d, logic c, logic o);
      line_report_t got, want;
      got = {d, c, o};
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: depth %0d complete %0b overflow %0b", d, c, o);
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected depth %0d complete %0b overflow %0b,",
                   want.depth, want.complete, want.overflow,
                   " got depth %0d complete %0b overflow %0b", d, c, o);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_text_byte = 8'h00;
  logic                   in_line_end = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DEPTH_OUT_W-1:0] out_open_depth;
  logic                   out_expression_complete;
  logic                   out_stack_overflow;

  closer_scoreboard sb = new;

  int burst_left;
  int stall_left;
  int stall_mode;
  bit deep_pushing;
  bit unwinding;
  int overflows_left;

  // {line_end, byte}
  logic [8:0] opening_seq [29] = '{
    {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
    {1'b0, CH_RROUND}, {1'b0, CH_LROUND}, {1'b0, CH_RSQUARE}, {1'b0, CH_LSQUARE},
    {1'b0, CH_LCURLY}, {1'b0, CH_RCURLY}, {1'b0, CH_RSQUARE}, {1'b0, CH_RROUND},
    {1'b0, CH_SQUOTE}, {1'b0, CH_BSLASH}, {1'b0, CH_SQUOTE}, {1'b0, CH_DQUOTE},
    {1'b0, CH_SQUOTE},
    {1'b0, CH_DQUOTE}, {1'b0, CH_BSLASH}, {1'b1, 8'h00}, {1'b0, CH_DQUOTE},
    {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b0, CH_SLASH}, {1'b0, CH_STAR},
    {1'b0, CH_SLASH}, {1'b0, CH_STAR},
    {1'b0, CH_HASH}, {1'b0, CH_LROUND}, {1'b1, 8'h00}
  };

  open_bracket_quote_tracker_unit uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_text_byte            (in_text_byte),
    .in_line_end             (in_line_end),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_open_depth          (out_open_depth),
    .out_expression_complete (out_expression_complete),
    .out_stack_overflow      (out_stack_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] opener_char(int sel);
    case (sel)
      0: return CH_LROUND;
      1: return CH_LSQUARE;
      default: return CH_LCURLY;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(kind_t k);
    case (k)
      K_ROUND: return CH_RROUND;
      K_SQUARE: return CH_RSQUARE;
      default: return CH_RCURLY;
    endcase
  endfunction

  // next random item, steered by the tracked state so that most text is well formed
  function automatic void next_item(output logic [7:0] b, output logic le);
    int    r;
    kind_t t;
    r  = $urandom_range(0, 99);
    t  = sb.top_kind();
    le = 1'b0;
    b  = 8'($urandom_range(0, 255));
    if (sb.line_skipped) begin
      le = (r < 30);
    end else if (t == K_SQUOTE || t == K_DQUOTE) begin
      if (r < 5) le = 1'b1;
      else if (r < 30) b = (t == K_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
      else if (r < 40) b = CH_BSLASH;
      else if (r < 45) b = (t == K_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
    end else if (t == K_COMMENT) begin
      if (r < 5) le = 1'b1;
      else if (r < 30) b = CH_STAR;
      else if (r < 50) b = CH_SLASH;
    end else if (deep_pushing) begin
      if (sb.depth_now < STACK_DEPTH_DEF) begin
        b = opener_char($urandom_range(0, 2));
      end else begin
        case ($urandom_range(0, 5))
          0, 1, 2: b = opener_char($urandom_range(0, 2));
          3: b = CH_SQUOTE;
          4: b = CH_DQUOTE;
          default: b = sb.slash_on ? CH_STAR : CH_SLASH;
        endcase
        overflows_left--;
        if (overflows_left <= 0) begin
          deep_pushing = 1'b0;
          unwinding    = 1'b1;
        end
      end
    end else begin
      if (unwinding && sb.depth_now < 8) unwinding = 1'b0;
      if (unwinding && r < 70) begin
        b = closer_of(t);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 7) le = 1'b1;
        else if (r < 22) b = opener_char($urandom_range(0, 2));
        else if (r < 42) b = closer_of(t);
        else if (r < 47) b = closer_of(kind_t'($urandom_range(0, 2)));
        else if (r < 52) b = CH_SQUOTE;
        else if (r < 56) b = CH_DQUOTE;
        else if (r < 61) b = CH_SLASH;
        else if (r < 64) b = CH_STAR;
        else if (r < 66) b = CH_HASH;
      end
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic le);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_line_end  <= le;
    do @(posedge clk); while (in_stall);
    sb.note_item(b, le);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_open_depth, out_expression_complete, out_stack_overflow);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(4, 40);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  initial begin
    logic [7:0] b;
    logic       le;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (opening_seq[k]) send_item(opening_seq[k][7:0], opening_seq[k][8]);
    for (int i = 0; i < 650; i++) begin
      if (!deep_pushing && !unwinding &&
          (i == 150 || i == 420 || $urandom_range(0, 249) == 0)) begin
        deep_pushing   = 1'b1;
        overflows_left = $urandom_range(2, 6);
      end
      next_item(b, le);
      send_item(b, le);
    end
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
